// ===== design/plme_pkg.sv =====
// Package with shared types and constants of the packet length marker encoder.
package plme_pkg;

   // Largest segment, in bytes, counting the index byte.
   localparam logic [16:0] SEGMENT_CAPACITY = 17'd65531;
   // Marker (2), segment length (2) and index (1) bytes of every segment.
   localparam logic [31:0] HEADER_BYTES = 32'd5;
   localparam logic [7:0]  CONT_BIT = 8'h80;
   localparam logic [6:0]  GROUP_MASK = 7'h7F;
   localparam int          QUEUE_DEPTH = 2;
   localparam int          QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int          QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [2:0] code_len_type;

   typedef struct packed {
      logic [31:0]  packet_length;
      code_len_type code_len;
   } item_type;

   typedef struct packed {
      logic         head_valid;
      item_type     head;
   } head_type;

endpackage

// ===== design/plme_ifs.sv =====
// Channel interfaces of the packet length marker encoder.
interface plme_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] packet_length;
   modport source (output valid, output packet_length, input ready);
   modport sink (input valid, input packet_length, output ready);
endinterface

interface plme_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        segment_start;
   logic        last;
   logic [31:0] total_bytes;
   modport source (output valid, output out_byte, output byte_valid, output segment_start,
                   output last, output total_bytes, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input segment_start,
                 input last, input total_bytes, output ready);
endinterface

interface plme_csr_if;
   logic valid;
   logic ready;
   logic write_mode;
   modport source (output valid, output write_mode, input ready);
   modport sink (input valid, input write_mode, output ready);
endinterface

// ===== design/plme_front.sv =====
// Front end: accepts packet lengths, finds their code length and queues them.
module plme_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_length,
   input  logic              pop,
   output plme_pkg::head_type head_out
);
   import plme_pkg::*;

   item_type                 mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   item_type                 item;
   logic                     push;
   logic                     do_pop;

   // Number of 7-bit groups needed, most significant nonzero group decides.
   always_comb begin
      item.packet_length = in_length;
      if (in_length[31:28] != 4'd0) item.code_len = 3'd5;
      else if (in_length[27:21] != 7'd0) item.code_len = 3'd4;
      else if (in_length[20:14] != 7'd0) item.code_len = 3'd3;
      else if (in_length[13:7] != 7'd0) item.code_len = 3'd2;
      else item.code_len = 3'd1;
   end

   assign in_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push = in_valid && in_ready;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= item;
   end

   assign head_out.head_valid = (count_ff != '0);
   assign head_out.head = mem[rd_ptr_ff];

endmodule

// ===== design/plme_back.sv =====
// Back end: segment state, one result per cycle to the output register unless stalled.
module plme_back (
   input  logic               clock,
   input  logic               reset,
   input  plme_pkg::head_type head_in,
   output logic               pop,
   input  logic               cfg_write,
   input  logic               cfg_mode,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_byte_valid,
   output logic               out_segment_start,
   output logic               out_last,
   output logic [31:0]        out_total
);
   import plme_pkg::*;

   logic                mode_ff;
   logic [15:0]         fill_ff, fill_in;
   logic                open_ff, open_in;
   logic [7:0]          count_ff, count_in;
   logic [31:0]         total_ff, total_in;
   logic [2:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                bvalid_ff, bvalid_in;
   logic                start_ff, start_in;
   logic                last_ff, last_in;
   logic                out_free;
   logic                fire;
   logic                need_hdr;
   logic                fin;
   logic [2:0]          group_sel;
   logic [6:0]          group;
   code_len_type        nb;
   logic [31:0]         len;

   function automatic logic [6:0] pick_group(input logic [31:0] v, input logic [2:0] g);
      logic [6:0] r;
      case (g)
         3'd0: r = v[6:0];
         3'd1: r = v[13:7];
         3'd2: r = v[20:14];
         3'd3: r = v[27:21];
         3'd4: r = {3'b000, v[31:28]};
         default: r = '0;
      endcase
      return r & GROUP_MASK;
   endfunction

   assign nb = head_in.head.code_len;
   assign len = head_in.head.packet_length;
   assign out_free = !valid_ff || out_ready;
   assign fire = head_in.head_valid && out_free;
   assign need_hdr = (idx_ff == 3'd0) &&
                     (!open_ff || ({1'b0, fill_ff} + {14'd0, nb}) > SEGMENT_CAPACITY);
   assign fin = (idx_ff == nb - 3'd1);
   assign group_sel = nb - 3'd1 - idx_ff;
   assign group = pick_group(len, group_sel);

   always_comb begin
      fill_in = fill_ff;
      open_in = open_ff;
      count_in = count_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      valid_in = valid_ff && !out_ready;
      byte_in = byte_ff;
      bvalid_in = bvalid_ff;
      start_in = start_ff;
      last_in = last_ff;
      pop = 1'b0;
      if (fire) begin
         valid_in = 1'b1;
         if (!mode_ff) begin
            // Every length opens its own segment; its result carries no byte.
            open_in = 1'b1;
            fill_in = '0;
            count_in = count_ff + 8'd1;
            total_in = total_ff + HEADER_BYTES + {29'd0, nb};
            byte_in = '0;
            bvalid_in = 1'b0;
            start_in = 1'b0;
            last_in = 1'b1;
            pop = 1'b1;
         end else if (need_hdr) begin
            open_in = 1'b1;
            fill_in = 16'd1;
            count_in = count_ff + 8'd1;
            total_in = total_ff + HEADER_BYTES;
            byte_in = count_ff;
            bvalid_in = 1'b1;
            start_in = 1'b1;
            last_in = 1'b0;
         end else begin
            fill_in = fill_ff + 16'd1;
            total_in = total_ff + 32'd1;
            byte_in = {1'b0, group} | (fin ? 8'h00 : CONT_BIT);
            bvalid_in = 1'b1;
            start_in = 1'b0;
            last_in = fin;
            if (fin) begin
               idx_in = '0;
               pop = 1'b1;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         fill_ff <= '0;
         open_ff <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else if (cfg_write) begin
         mode_ff <= cfg_mode;
         fill_ff <= '0;
         open_ff <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
         idx_ff <= '0;
         valid_ff <= valid_in;
      end else begin
         fill_ff <= fill_in;
         open_ff <= open_in;
         count_ff <= count_in;
         total_ff <= total_in;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bvalid_ff <= bvalid_in;
      start_ff <= start_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte = byte_ff;
   assign out_byte_valid = bvalid_ff;
   assign out_segment_start = start_ff;
   assign out_last = last_ff;
   // The total shown with a result is the total after that result was counted.
   always_ff @(posedge clock) begin
      if (fire) out_total <= total_in;
   end

endmodule

// ===== design/packet_length_marker_encoder.sv =====
// Top level of the packet length marker encoder: front end, queue and back end.
//
//   channel   direction  payload                                             transfer when
//   req_chan  in         packet_length[31:0]                                 valid && ready
//   rsp_chan  out        out_byte, byte_valid, segment_start, last, total    valid && ready
//   csr_chan  in         write_mode                                          valid && ready
//
// Each length causes one result in count-only mode, and one to five code bytes plus an
// optional index byte in write mode. The single output register of the back end
// produces one byte per cycle while the result channel does not stall; results are
// registered there from the head of the two-entry queue. Reset is synchronous and
// active high and restores write mode with no segment open. A stalled result channel
// holds the output register while the front end keeps taking lengths until the queue
// is full.
module packet_length_marker_encoder (
   input logic       clock,
   input logic       reset,
   plme_req_if.sink  req_chan,
   plme_rsp_if.source rsp_chan,
   plme_csr_if.sink  csr_chan
);
   import plme_pkg::*;

   head_type head;
   logic     pop;
   logic     cfg_write;

   // Mode writes must arrive only while the block is idle, which the block does not enforce; they are always taken.
   assign csr_chan.ready = 1'b1;
   assign cfg_write = csr_chan.valid;

   // The front end classifies each length by its number of 7-bit groups.
   plme_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_length (req_chan.packet_length),
      .pop       (pop),
      .head_out  (head)
   );

   // The back end owns the segment state and walks the code bytes of the head item.
   plme_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_in           (head),
      .pop               (pop),
      .cfg_write         (cfg_write),
      .cfg_mode          (csr_chan.write_mode),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_byte          (rsp_chan.out_byte),
      .out_byte_valid    (rsp_chan.byte_valid),
      .out_segment_start (rsp_chan.segment_start),
      .out_last          (rsp_chan.last),
      .out_total         (rsp_chan.total_bytes)
   );

endmodule

// ===== design/plme_checker.sv =====
// Port-level checker of the packet length marker encoder and its bind statement.
module plme_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_segment_start,
   input logic        rsp_last,
   input logic [31:0] rsp_total_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_total_bytes)
                                  && $stable(rsp_last))
      else $error("stalled result changed");

   a_index_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_start |-> rsp_byte_valid && !rsp_last)
      else $error("index byte must carry data and be followed by code bytes");

   a_count_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && !rsp_segment_start
                                       && rsp_out_byte == 8'd0)
      else $error("count-only result malformed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind packet_length_marker_encoder plme_checker u_plme_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_byte      (rsp_chan.out_byte),
   .rsp_byte_valid    (rsp_chan.byte_valid),
   .rsp_segment_start (rsp_chan.segment_start),
   .rsp_last          (rsp_chan.last),
   .rsp_total_bytes   (rsp_chan.total_bytes)
);

// ===== verif/plme_checker.sv =====
// Checker that predicts the length marker bytes of the encoder and compares each result transfer.
module plme_scoreboard (
   input  logic clock,
   input  logic reset,
   plme_req_if  req_mon,
   plme_rsp_if  rsp_mon,
   plme_csr_if  csr_mon,
   output int   error_count,
   output int   bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import plme_pkg::*;

   typedef struct {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        segment_start;
      logic        last;
      logic [31:0] total_bytes;
   } marker_byte_type;

   marker_byte_type expected_bytes[$];

   logic        emit_bytes;
   logic [15:0] seg_fill;
   logic        seg_open;
   logic [7:0]  seg_count;
   logic [31:0] running_total;

   int failures = 0;
   int queued = 0;

   assign error_count = failures;
   assign bytes_pending = queued;

   function automatic int code_bytes(input logic [31:0] len);
      int n;
      n = 1;
      while (n < 5 && (len >> (7 * n)) != 0)
         n++;
      return n;
   endfunction

   function automatic void clear_segments();
      seg_fill = '0;
      seg_open = 1'b0;
      seg_count = '0;
      running_total = '0;
   endfunction

   // Appends one predicted result, carrying the current running total, to the stream.
   function automatic void add_expected(input logic [7:0] b, input logic bv, input logic st,
                                        input logic lst);
      marker_byte_type r;
      r.out_byte = b;
      r.byte_valid = bv;
      r.segment_start = st;
      r.last = lst;
      r.total_bytes = running_total;
      expected_bytes = {expected_bytes, r};
   endfunction

   // Appends the bytes that one packet length produces to the expected stream.
   function automatic void encode_length(input logic [31:0] len);
      int          nb;
      logic [7:0]  group;
      nb = code_bytes(len);
      if (!emit_bytes) begin
         // Count-only: every length opens a segment that is counted but never emitted.
         seg_open = 1'b1;
         seg_fill = '0;
         seg_count = seg_count + 8'd1;
         running_total = running_total + HEADER_BYTES + 32'(nb);
         add_expected(8'h00, 1'b0, 1'b0, 1'b1);
         return;
      end
      if (!seg_open || int'(seg_fill) + nb > int'(SEGMENT_CAPACITY)) begin
         running_total = running_total + HEADER_BYTES;
         add_expected(seg_count, 1'b1, 1'b1, 1'b0);
         seg_count = seg_count + 8'd1;
         seg_open = 1'b1;
         seg_fill = 16'd1;
      end
      for (int i = 0; i < nb; i++) begin
         group = {1'b0, 7'(len >> (7 * (nb - 1 - i))) & GROUP_MASK};
         if (i != nb - 1)
            group = group | CONT_BIT;
         seg_fill = seg_fill + 16'd1;
         running_total = running_total + 32'd1;
         add_expected(group, 1'b1, 1'b0, (i == nb - 1));
      end
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] seen);
      if (seen !== want) begin
         failures++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
                  want, seen);
      end
   endfunction

   always @(posedge clock) begin
      marker_byte_type seen;
      marker_byte_type want;
      if (reset) begin
         emit_bytes = 1'b1;
         clear_segments();
         expected_bytes.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            clear_segments();
            emit_bytes = csr_mon.write_mode;
         end
         if (req_mon.valid && req_mon.ready)
            encode_length(req_mon.packet_length);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.out_byte, rsp_mon.byte_valid, rsp_mon.segment_start,
                     rsp_mon.last, rsp_mon.total_bytes};
            if (expected_bytes.size() == 0) begin
               failures++;
               $display("%0t ns: unexpected result, expected none, actual byte 0x%0h",
                        $time, seen.out_byte);
            end else begin
               want = expected_bytes.pop_front();
               compare_field("out_byte", 32'(want.out_byte), 32'(seen.out_byte));
               compare_field("byte_valid", 32'(want.byte_valid), 32'(seen.byte_valid));
               compare_field("segment_start", 32'(want.segment_start),
                             32'(seen.segment_start));
               compare_field("last", 32'(want.last), 32'(seen.last));
               compare_field("total_bytes", want.total_bytes, seen.total_bytes);
            end
         end
      end
      queued <= expected_bytes.size();
   end

endmodule

// ===== verif/tb_packet_length_marker_encoder.sv =====
// Testbench top of the packet length marker encoder: clock, reset, stimulus and verdict.
module tb_packet_length_marker_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   // Bound on the length of the run, counted in clock cycles.
   localparam int CYCLE_LIMIT = 50000;
   // Cycles allowed for the block to settle after the last expected byte has come out.
   localparam int SETTLE_CYCLES = 8;

   logic clock;
   logic reset;

   plme_req_if req_chan ();
   plme_rsp_if rsp_chan ();
   plme_csr_if csr_chan ();

   int error_count;
   int bytes_pending;
   int cycle_count = 0;

   // Idle controls set by the stimulus process; the result sink reads the response ones.
   logic req_idle_on = 1'b0;
   logic rsp_idle_on = 1'b0;
   int   rsp_hold_cycles = 0;

   packet_length_marker_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   plme_scoreboard checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .error_count   (error_count),
      .bytes_pending (bytes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hung handshake or a result that never comes ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_packet_length_marker_encoder: done, errors");
         $finish;
      end
   end

   // Result sink. When idling is on it may hold ready low for a random number of cycles
   // before each transfer, and when the stimulus asks for back pressure it holds off for a
   // long stretch so that the block's queue fills and the request side stalls.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_idle_on) begin
            gap = $urandom_range(4, 0);
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Draws a length whose code takes the given number of bytes; zero picks that number at
   // random. Each class spans from its smallest to its largest value, but zero is never drawn.
   function automatic logic [31:0] length_with_code(input int code_len);
      int          n;
      logic [63:0] lo;
      logic [63:0] hi;
      n = (code_len == 0) ? int'($urandom_range(5, 1)) : code_len;
      lo = (n == 1) ? 64'd1 : 64'd1 << (7 * (n - 1));
      hi = (n == 5) ? 64'hFFFF_FFFF : (64'd1 << (7 * n)) - 64'd1;
      return $urandom_range(32'(hi), 32'(lo));
   endfunction

   // Offers one length and returns at the edge where its transfer happens. Valid stays
   // high into the next item when no gap is drawn, so back-to-back transfers occur.
   task automatic send_length(input logic [31:0] len);
      int gap;
      gap = req_idle_on ? int'($urandom_range(4, 0)) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.packet_length <= len;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_length(length_with_code(0));
   endtask

   // Stops offering lengths and waits until every predicted byte has been seen. The first
   // edge lets the checker count a transfer that happened at the calling edge.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the mode register. Every write restarts the segment stream from scratch.
   task automatic write_mode_reg(input logic mode);
      csr_chan.valid <= 1'b1;
      csr_chan.write_mode <= mode;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.packet_length <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.write_mode <= 1'b1;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Write mode out of reset. The first length opens segment zero; the rest cover the
      // edges of every code length from one to five bytes, and the all-ones, top-bit-only
      // and alternating patterns so that every bit of the length takes both values.
      send_length(32'h0000_0001);
      send_length(32'h0000_007F);
      send_length(32'h0000_0080);
      send_length(32'h0000_3FFF);
      send_length(32'h0000_4000);
      send_length(32'h001F_FFFF);
      send_length(32'h0020_0000);
      send_length(32'h0FFF_FFFF);
      send_length(32'h1000_0000);
      send_length(32'hFFFF_FFFF);
      send_length(32'h8000_0000);
      send_length(32'h5555_5555);
      send_length(32'hAAAA_AAAA);
      drain();

      // Long receiver stall while lengths keep coming without gaps, so the block fills up
      // and pushes back on the request side.
      rsp_hold_cycles = 60;
      send_random(20);

      // Random gaps on both sides.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_random(25);

      // The sender pauses until every byte is out, then runs on with no idling at all.
      drain();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random(20);
      drain();

      // Count-only mode: one result per length, total grows by header plus code length.
      write_mode_reg(1'b0);
      send_length(32'h0000_0001);
      send_length(32'hFFFF_FFFF);
      send_length(32'h0000_0080);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_random(30);
      drain();

      // Back to write mode: a fresh stream starting at segment zero.
      write_mode_reg(1'b1);
      send_random(30);
      drain();

      // Finish in count-only mode with gaps on both sides.
      write_mode_reg(1'b0);
      send_random(5);
      drain();

      if (error_count == 0) begin
         $display("tb_packet_length_marker_encoder: done, clean");
      end else begin
         $display("tb_packet_length_marker_encoder: done, errors");
      end
      $finish;
   end

endmodule
